@@ rtl/chull_pkg.sv @@
// Package: shared constants and the sequencer state enum type for the hull block.
package chull_pkg;
  localparam int unsigned MaxPointsDef = 32;
  localparam int unsigned CoordBitsDef = 16;
  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE,
    S_START,       // pick sort, two-point copy or direct chain
    S_SORT_LD,     // read pts[i]
    S_SORT_LDW,    // hold pts[i] as the point being inserted
    S_SORT_RD,     // read pts[j-1]
    S_SORT_CMP,    // compare, maybe shift pts[j-1] up
    S_SORT_PUT,    // drop the held point into its slot
    S_TWO,         // two-point case, copy p0 p1 p0
    S_CH_RD,       // read next sorted point
    S_CH_WAIT,
    S_CH_TEST,     // read the two chain top vertices
    S_CH_MUL,      // products registered
    S_CH_DEC,      // pop or push
    S_CH_PUSH,
    S_EMIT_RD,
    S_EMIT_OUT,
    S_Q_RD,
    S_Q_MUL,
    S_Q_DEC,
    S_RESULT
  } state_t;
endpackage

@@ rtl/chull_if.sv @@
// Interfaces: valid/ready channels for input and result items.
interface chull_in_if #(parameter int unsigned CoordBits = 16);
  logic valid;
  logic ready;
  logic cmd;
  logic signed [CoordBits-1:0] px;
  logic signed [CoordBits-1:0] py;
  logic last;
  modport source (output valid, cmd, px, py, last, input ready);
  modport sink (input valid, cmd, px, py, last, output ready);
endinterface

interface chull_out_if #(parameter int unsigned CoordBits = 16);
  logic valid;
  logic ready;
  logic signed [CoordBits-1:0] out_x;
  logic signed [CoordBits-1:0] out_y;
  logic is_query;
  logic inside_res;
  logic error;
  logic end_of_run;
  modport source (output valid, out_x, out_y, is_query, inside_res, error, end_of_run,
                  input ready);
  modport sink (input valid, out_x, out_y, is_query, inside_res, error, end_of_run,
                output ready);
endinterface

@@ rtl/chull_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module chull_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/convex_hull_with_containment_top.sv @@
// Top level: monotone-chain convex hull builder with point-in-hull query.
//
// Usage. One input channel (in) carries items {cmd, px, py, last}; one
// result channel (out) carries {out_x, out_y, is_query, inside_res, error,
// end_of_run}. Both are valid/ready; an item moves when valid and ready are
// high at a rising clk edge.
//  - Load item (cmd 0) without last: stored, in.ready stays high, so
//    loads go back to back. Loads past MaxPoints are dropped and flagged.
//  - Load with last: a start step; insertion sort (load, hold, then read and
//    compare per shift, up to n*(n-1)/2 shifts, then put); lower then upper
//    chain (2n-1 point visits, each a read, cross-product tests, a push);
//    then the closed hull is emitted one vertex at a time. Two points skip
//    the sort and chain: a copy of p0 p1 p0, then 3 vertices.
//  - Query item (cmd 1): one result, after the hull edges are tested in turn
//    (read, multiply, decide) until one rejects the point or none is left.
// Throughput: one item at a time; in.ready is high only while idle. The
// single shared cross-product unit (two registered multipliers and one
// compare) and the one read port of the point memory pace the steps above.
// A result waiting in the output register does not hold off loads.
// Reset (rst, synchronous): counts and flags clear; hull empty; memory
// contents are not cleared, only written entries are ever read.
// Stall: a result is held in the output register until out.ready is high;
// the sequencer waits with the next one.
module convex_hull_with_containment_top #(
  parameter int unsigned MaxPoints = chull_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = chull_pkg::CoordBitsDef
) (
  input logic clk,
  input logic rst,
  chull_in_if.sink    in,
  chull_out_if.source out
);
  import chull_pkg::*;

  localparam int unsigned PW  = $clog2(MaxPoints);      // point index
  localparam int unsigned CW  = $clog2(MaxPoints + 1);  // point count
  localparam int unsigned HD  = 2 * MaxPoints + 2;      // chain work store
  localparam int unsigned HW  = $clog2(HD);
  localparam int unsigned VW  = 2 * CoordBits;
  localparam int unsigned DW  = CoordBits + 1;          // differences
  localparam int unsigned MW  = 2 * DW;                 // products

  state_t state, state_next;

  // counters and flags
  logic [CW-1:0] count;        // points held
  logic          overflow;
  logic [HW-1:0] hlen;         // hull length incl. closing vertex
  logic [CW-1:0] si, sj;       // sort indices / chain loop index / copy step
  logic [HW-1:0] k;            // chain top
  logic [HW-1:0] t;            // upper-chain floor
  logic          upper;        // building upper chain
  logic [HW-1:0] e;            // emit / query index
  logic          err_run;
  logic          ins;
  logic [VW-1:0] vp;           // point in hand: inserted, pushed or queried

  // point memory (sort happens in place)
  logic          p_we;
  logic [PW-1:0] p_wa, p_ra;
  logic [VW-1:0] p_wd, p_rd;
  // chain memory; two read copies give top and top-1 in one read
  logic          h_we;
  logic [HW-1:0] h_wa, h_ra0, h_ra1;
  logic [VW-1:0] h_wd, h_rd0, h_rd1;

  chull_ram #(.Width(VW), .Depth(MaxPoints)) u_pts (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  chull_ram #(.Width(VW), .Depth(HD)) u_hull0 (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra0), .rdata(h_rd0));
  chull_ram #(.Width(VW), .Depth(HD)) u_hull1 (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra1), .rdata(h_rd1));

  // held point and the point just read from the store
  logic signed [CoordBits-1:0] rx, ry, sx, sy;
  assign rx = vp[VW-1:CoordBits];
  assign ry = vp[CoordBits-1:0];
  assign sx = p_rd[VW-1:CoordBits];
  assign sy = p_rd[CoordBits-1:0];

  logic sort_less;   // held point sorts before pts[j-1]
  logic sort_last;   // last point inserted
  assign sort_less = (rx < sx) || ((rx == sx) && (ry < sy));
  assign sort_last = (si + CW'(1) >= count);

  // shared cross-product unit: m1 = d1x*d2y, m2 = d1y*d2x (registered)
  // o = h[k-2] or edge start, q = h[k-1] or edge end, r = held point
  logic signed [CoordBits-1:0] ox, oy, qx, qy;
  logic signed [DW-1:0] d1x, d1y, d2x, d2y;
  logic signed [MW-1:0] prod1, prod2, m1, m2;
  assign ox = h_rd0[VW-1:CoordBits];
  assign oy = h_rd0[CoordBits-1:0];
  assign qx = h_rd1[VW-1:CoordBits];
  assign qy = h_rd1[CoordBits-1:0];
  assign d1x = DW'(qx) - DW'(ox);
  assign d1y = DW'(qy) - DW'(oy);
  assign d2x = DW'(rx) - DW'(ox);
  assign d2y = DW'(ry) - DW'(oy);
  assign prod1 = MW'(d1x) * MW'(d2y);
  assign prod2 = MW'(d1y) * MW'(d2x);

  logic can_pop, turn_pop, chain_done;
  logic [HW-1:0] hull_len_cap;
  assign can_pop  = upper ? (k >= t) : (k >= HW'(2));
  assign turn_pop = (m1 <= m2);
  // evaluated at the push; lower chain of a single point ends the build
  assign chain_done = upper ? (sj == '0) : ((sj + CW'(1) >= count) && (count < CW'(2)));
  assign hull_len_cap = (k >= HW'(MaxPoints)) ? HW'(MaxPoints + 1) : k + HW'(1);

  // output register
  logic o_valid;
  logic signed [CoordBits-1:0] o_x, o_y;
  logic o_q, o_in, o_err, o_eor;
  logic o_load;
  logic last_vtx;
  assign out.valid      = o_valid;
  assign out.out_x      = o_x;
  assign out.out_y      = o_y;
  assign out.is_query   = o_q;
  assign out.inside_res = o_in;
  assign out.error      = o_err;
  assign out.end_of_run = o_eor;

  assign o_load   = ((state == S_EMIT_OUT) || (state == S_RESULT)) && (!o_valid || out.ready);
  assign last_vtx = (e + HW'(1) == hlen);

  logic accept;
  assign in.ready = (state == S_IDLE);
  assign accept   = in.valid && in.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in.cmd == CmdQuery) begin
            state_next = (hlen > HW'(1)) ? S_Q_RD : S_RESULT;
          end else if (in.last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (count == CW'(2)) state_next = S_TWO;
        else if (count < CW'(2)) state_next = S_CH_RD;
        else state_next = S_SORT_LD;
      end
      S_SORT_LD:   state_next = S_SORT_LDW;
      S_SORT_LDW:  state_next = S_SORT_RD;
      S_SORT_RD:   state_next = S_SORT_CMP;
      S_SORT_CMP:  state_next = (sort_less && sj != CW'(1)) ? S_SORT_RD : S_SORT_PUT;
      S_SORT_PUT:  state_next = sort_last ? S_CH_RD : S_SORT_LD;
      S_TWO:       state_next = (sj == CW'(3)) ? S_EMIT_RD : S_TWO;
      S_CH_RD:     state_next = S_CH_WAIT;
      S_CH_WAIT:   state_next = S_CH_TEST;
      S_CH_TEST:   state_next = can_pop ? S_CH_MUL : S_CH_PUSH;
      S_CH_MUL:    state_next = S_CH_DEC;
      S_CH_DEC:    state_next = turn_pop ? S_CH_TEST : S_CH_PUSH;
      S_CH_PUSH:   state_next = chain_done ? S_EMIT_RD : S_CH_RD;
      S_EMIT_RD:   state_next = S_EMIT_OUT;
      S_EMIT_OUT: begin
        if (o_load) state_next = last_vtx ? S_IDLE : S_EMIT_RD;
      end
      S_Q_RD:      state_next = S_Q_MUL;
      S_Q_MUL:     state_next = S_Q_DEC;
      S_Q_DEC:     state_next = ((m1 < m2) || (e + HW'(2) >= hlen)) ? S_RESULT : S_Q_RD;
      S_RESULT: begin
        if (o_load) state_next = S_IDLE;
      end
      default:     state_next = S_IDLE;
    endcase
  end

  // memory port steering
  always_comb begin
    p_we  = 1'b0;
    p_wa  = '0;
    p_wd  = '0;
    p_ra  = '0;
    h_we  = 1'b0;
    h_wa  = '0;
    h_wd  = '0;
    h_ra0 = '0;
    h_ra1 = '0;
    case (state)
      S_IDLE: begin
        p_we = accept && (in.cmd == CmdLoad) && (count < CW'(MaxPoints));
        p_wa = PW'(count);
        p_wd = {in.px, in.py};
      end
      S_SORT_LD: p_ra = PW'(si);
      S_SORT_RD: p_ra = PW'(sj - CW'(1));
      S_SORT_CMP: begin
        p_we = sort_less;
        p_wa = PW'(sj);
        p_wd = p_rd;
      end
      S_SORT_PUT: begin
        p_we = 1'b1;
        p_wa = PW'(sj);
        p_wd = vp;
      end
      S_TWO: begin
        // step 1 writes p0, step 2 p1, step 3 p0 again
        p_ra = (sj == CW'(1)) ? PW'(1) : '0;
        h_we = (sj != '0);
        h_wa = HW'(sj) - HW'(1);
        h_wd = p_rd;
      end
      S_CH_RD: p_ra = PW'(sj);
      S_CH_TEST: begin
        h_ra0 = k - HW'(2);
        h_ra1 = k - HW'(1);
      end
      S_CH_PUSH: begin
        h_we = 1'b1;
        h_wa = k;
        h_wd = vp;
      end
      S_EMIT_RD:  h_ra0 = e;
      S_EMIT_OUT: h_ra0 = e;     // keep read data while the receiver stalls
      S_Q_RD: begin
        h_ra0 = e;
        h_ra1 = e + HW'(1);
      end
      default: ;
    endcase
  end

  // datapath and loop control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overflow <= 1'b0;
      hlen     <= '0;
      o_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (o_load) o_valid <= 1'b1;
      else if (out.ready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            vp <= {in.px, in.py};
            e  <= '0;
            if (in.cmd == CmdQuery) begin
              // no hull: error; single vertex: no edges, inside
              ins     <= (hlen != '0);
              err_run <= (hlen == '0);
            end else begin
              if (count < CW'(MaxPoints)) count <= count + CW'(1);
              else overflow <= 1'b1;
              if (in.last) begin
                err_run <= overflow || !(count < CW'(MaxPoints));
                si      <= CW'(1);
                sj      <= '0;
                k       <= '0;
                upper   <= 1'b0;
              end
            end
          end
        end
        S_SORT_LDW: begin
          vp <= p_rd;
          sj <= si;
        end
        S_SORT_CMP: begin
          if (sort_less) sj <= sj - CW'(1);
        end
        S_SORT_PUT: begin
          if (sort_last) sj <= '0;
          else si <= si + CW'(1);
        end
        S_TWO: begin
          sj <= sj + CW'(1);
          if (sj == CW'(3)) hlen <= HW'(3);
        end
        S_CH_WAIT: vp <= p_rd;
        S_CH_MUL, S_Q_MUL: begin
          m1 <= prod1;
          m2 <= prod2;
        end
        S_CH_DEC: begin
          if (turn_pop) k <= k - HW'(1);
        end
        S_CH_PUSH: begin
          k <= k + HW'(1);
          if (chain_done) begin
            hlen <= hull_len_cap;
          end else if (!upper) begin
            if (sj + CW'(1) >= count) begin
              upper <= 1'b1;
              t     <= k + HW'(2);
              sj    <= count - CW'(2);
            end else begin
              sj <= sj + CW'(1);
            end
          end else begin
            sj <= sj - CW'(1);
          end
        end
        S_EMIT_OUT: begin
          if (o_load) begin
            o_x   <= h_rd0[VW-1:CoordBits];
            o_y   <= h_rd0[CoordBits-1:0];
            o_q   <= 1'b0;
            o_in  <= 1'b0;
            o_err <= err_run;
            o_eor <= last_vtx;
            e     <= e + HW'(1);
            if (last_vtx) begin
              count    <= '0;
              overflow <= 1'b0;
            end
          end
        end
        S_Q_DEC: begin
          // edge a=h[e], b=h[e+1]; point right of the edge is outside
          if (m1 < m2) ins <= 1'b0;
          else e <= e + HW'(1);
        end
        S_RESULT: begin
          if (o_load) begin
            o_x   <= '0;
            o_y   <= '0;
            o_q   <= 1'b1;
            o_in  <= ins;
            o_err <= err_run;
            o_eor <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in.ready |-> state == S_IDLE)
    else $error("ready outside idle");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MaxPoints))
    else $error("point count beyond capacity");
  a_query_zero: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.is_query) |-> (out.out_x == '0 && out.out_y == '0 && out.end_of_run))
    else $error("query result malformed");
  a_hull_len: assert property (@(posedge clk) disable iff (rst)
    hlen <= HW'(MaxPoints + 1))
    else $error("hull too long");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out.valid && !out.ready) |=> (out.valid && $stable(out.out_x) && $stable(out.out_y)
      && $stable(out.end_of_run)))
    else $error("result changed while stalled");
endmodule

@@ tb/chull_checker.sv @@
// Checker: watches both hull channels, predicts results and compares them.
module chull_checker (
  input  logic        clk,
  input  logic        rst,
  chull_in_if.sink    in_mon,
  chull_out_if.sink   out_mon,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import chull_pkg::*;

  localparam int Cap = int'(MaxPointsDef);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic q;
    logic ins;
    logic err;
    logic eor;
  } hull_res_t;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  pt_t       set_pts[Cap];
  pt_t       hull_vtx[Cap+1];
  int        set_n;
  int        hull_n;
  bit        dropped;
  hull_res_t expected_q[$];

  // true when o->a->b turns right or is straight
  function automatic bit turns_right(pt_t o, pt_t a, pt_t b);
    return (a.x - o.x) * (b.y - o.y) <= (a.y - o.y) * (b.x - o.x);
  endfunction

  function automatic bit pt_less(pt_t a, pt_t b);
    return a.x < b.x || (a.x == b.x && a.y < b.y);
  endfunction

  task automatic build_hull();
    pt_t srt[Cap];
    pt_t chain[2*Cap+2];
    pt_t v;
    int  n, i, j, k, t;
    n = set_n;
    k = 0;
    if (n == 2) begin
      hull_vtx[0] = set_pts[0];
      hull_vtx[1] = set_pts[1];
      hull_vtx[2] = set_pts[0];
      hull_n = 3;
      return;
    end
    for (i = 0; i < n; i++) srt[i] = set_pts[i];
    for (i = 1; i < n; i++) begin
      v = srt[i];
      j = i;
      while (j > 0 && pt_less(v, srt[j-1])) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = v;
    end
    for (i = 0; i < n; i++) begin
      while (k >= 2 && turns_right(chain[k-2], chain[k-1], srt[i])) k--;
      chain[k++] = srt[i];
    end
    t = k + 1;
    for (j = n; j >= 2; j--) begin
      while (k >= t && turns_right(chain[k-2], chain[k-1], srt[j-2])) k--;
      chain[k++] = srt[j-2];
    end
    if (k > Cap + 1) k = Cap + 1;
    for (i = 0; i < k; i++) hull_vtx[i] = chain[i];
    hull_n = k;
  endtask

  task automatic predict_item(logic cmd, logic signed [15:0] px,
                              logic signed [15:0] py, logic lst);
    hull_res_t r;
    pt_t       p;
    bit        in_hull;
    longint    dx, dy;
    bit        err;
    p.x = px;
    p.y = py;
    r = '0;
    if (cmd == CmdQuery) begin
      r.q = 1'b1;
      r.eor = 1'b1;
      if (hull_n == 0) begin
        r.err = 1'b1;
      end else begin
        in_hull = 1'b1;
        for (int i = 0; i + 1 < hull_n; i++) begin
          dx = hull_vtx[i+1].x - hull_vtx[i].x;
          dy = hull_vtx[i+1].y - hull_vtx[i].y;
          if (dx * (p.y - hull_vtx[i].y) < dy * (p.x - hull_vtx[i].x)) begin
            in_hull = 1'b0;
            break;
          end
        end
        r.ins = in_hull;
      end
      expected_q.insert(expected_q.size(), r);
      return;
    end
    if (set_n < Cap) set_pts[set_n++] = p;
    else dropped = 1'b1;
    if (!lst) return;
    err = dropped;
    build_hull();
    set_n = 0;
    dropped = 1'b0;
    for (int i = 0; i < hull_n; i++) begin
      r.x = 16'(hull_vtx[i].x);
      r.y = 16'(hull_vtx[i].y);
      r.err = err;
      r.eor = (i + 1 == hull_n);
      expected_q.insert(expected_q.size(), r);
    end
  endtask

  always @(posedge clk) begin
    hull_res_t e;
    if (rst) begin
      set_n = 0;
      hull_n = 0;
      dropped = 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.cmd, in_mon.px, in_mon.py, in_mon.last);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: x=%0d y=%0d", out_mon.out_x, out_mon.out_y);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_mon.out_x !== e.x || out_mon.out_y !== e.y ||
              out_mon.is_query !== e.q || out_mon.inside_res !== e.ins ||
              out_mon.error !== e.err || out_mon.end_of_run !== e.eor) begin
            if (out_mon.out_x !== e.x) $error("out_x exp %0d got %0d", e.x, out_mon.out_x);
            if (out_mon.out_y !== e.y) $error("out_y exp %0d got %0d", e.y, out_mon.out_y);
            if (out_mon.is_query !== e.q)
              $error("is_query exp %0b got %0b", e.q, out_mon.is_query);
            if (out_mon.inside_res !== e.ins)
              $error("inside_res exp %0b got %0b", e.ins, out_mon.inside_res);
            if (out_mon.error !== e.err)
              $error("error exp %0b got %0b", e.err, out_mon.error);
            if (out_mon.end_of_run !== e.eor)
              $error("end_of_run exp %0b got %0b", e.eor, out_mon.end_of_run);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

@@ tb/convex_hull_with_containment_top_tb.sv @@
// Testbench top: drives load/query items into the hull block and gives the verdict.
module convex_hull_with_containment_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import chull_pkg::*;

  // The slowest set: 32 points held -> ~500 sort shifts plus the chain build,
  // all with no acceptance; the limit below is several times that long.
  localparam int StallLimit = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   idle_pct = 27;       // chance of a gap on either side, in percent
  int   loads_sent, queries_sent, sets_built;
  int   quiet_cycles;
  bit   timed_out;

  chull_in_if  #(.CoordBits(16)) in_ch ();
  chull_out_if #(.CoordBits(16)) out_ch ();

  convex_hull_with_containment_top dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch.sink),
    .out (out_ch.source)
  );

  chull_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch.sink),
    .out_mon    (out_ch.sink),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Receiver: random back-pressure at the idle rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One item: optional gap, then hold valid until accepted.
  task automatic send_item(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                           logic lst);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.px <= x;
    in_ch.py <= y;
    in_ch.last <= lst;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CmdQuery) queries_sent++;
    else loads_sent++;
    if (cmd == CmdLoad && lst) sets_built++;
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_coord(int span);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r == 2) return 16'($urandom());    // full range, every bit toggles
    return 16'($signed(span) - $signed($urandom_range(2 * span)));
  endfunction

  // Random set of n points (duplicates and clusters likely), then queries.
  task automatic random_set(int n, int nq, int span);
    for (int i = 0; i < n; i++)
      send_item(CmdLoad, rand_coord(span), rand_coord(span), i == n - 1);
    for (int i = 0; i < nq; i++)
      send_item(CmdQuery, rand_coord(span), rand_coord(span), 1'($urandom_range(1)));
  endtask

  initial begin
    int n;
    in_ch.valid = 1'b0;
    in_ch.cmd = CmdLoad;
    in_ch.px = '0;
    in_ch.py = '0;
    in_ch.last = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: query with no hull yet (error case).
    send_item(CmdQuery, 16'sd0, 16'sd0, 1'b1);
    // Single point hull; queries anywhere are inside.
    send_item(CmdLoad, 16'sh7FFF, 16'sh8000, 1'b1);
    send_item(CmdQuery, 16'sh8000, 16'sh7FFF, 1'b0);
    // Two points keep arrival order.
    send_item(CmdLoad, 16'sd5, 16'sd5, 1'b0);
    send_item(CmdLoad, -16'sd5, -16'sd5, 1'b1);
    send_item(CmdQuery, 16'sd0, 16'sd0, 1'b0);
    send_item(CmdQuery, 16'sd1, 16'sd0, 1'b0);
    // Square at the coordinate extremes, plus collinear edge point and center.
    send_item(CmdLoad, 16'sh8000, 16'sh8000, 1'b0);
    send_item(CmdLoad, 16'sh7FFF, 16'sh8000, 1'b0);
    send_item(CmdLoad, 16'sd0, 16'sh8000, 1'b0);
    send_item(CmdLoad, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_item(CmdLoad, 16'sd0, 16'sd0, 1'b0);
    send_item(CmdLoad, 16'sh8000, 16'sh7FFF, 1'b1);
    send_item(CmdQuery, 16'sh7FFF, 16'sd0, 1'b0);   // on an edge
    send_item(CmdQuery, 16'sd0, 16'sd0, 1'b0);
    // Degenerate: repeated and collinear points.
    send_item(CmdLoad, 16'sd3, 16'sd3, 1'b0);
    send_item(CmdLoad, 16'sd3, 16'sd3, 1'b0);
    send_item(CmdLoad, 16'sd3, 16'sd3, 1'b1);
    send_item(CmdQuery, 16'sd4, 16'sd3, 1'b0);
    send_item(CmdLoad, 16'sd0, 16'sd0, 1'b0);
    send_item(CmdLoad, 16'sd2, 16'sd2, 1'b0);
    send_item(CmdLoad, 16'sd1, 16'sd1, 1'b1);
    send_item(CmdQuery, 16'sd1, 16'sd2, 1'b0);
    // Overflow: 34 loads, the last two dropped and flagged.
    random_set(34, 2, 30000);

    // Random part; first stretch has no idling at all.
    idle_pct = 0;
    for (int s = 0; s < 6; s++) random_set($urandom_range(3, 8), 2, 50);
    idle_pct = 27;
    while (loads_sent + queries_sent < 480) begin
      case ($urandom_range(9))
        0: n = $urandom_range(30, 35);
        1: n = $urandom_range(1, 2);
        default: n = $urandom_range(3, 10);
      endcase
      random_set(n, $urandom_range(1, 4), ($urandom_range(1) != 0) ? 20 : 32767);
    end
    drop_valid();
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Covered %0d loads in %0d sets and %0d containment queries.",
             loads_sent, sets_built, queries_sent);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
